// ----- rtl/core/mfhd_pkg.sv -----
package mfhd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned NIBBLE_W    = 4;
    localparam int unsigned LEN_W       = 28;
    localparam int unsigned LEN_DIGIT_W = 7;
    localparam int unsigned LEN_CNT_W   = 3;
    localparam int unsigned MAX_LENGTH_BYTES = 4;

    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [NIBBLE_W-1:0] packet_type;
        logic [NIBBLE_W-1:0] packet_flags;
        logic [LEN_W-1:0]    remaining_length;
        logic [BYTE_W-1:0]   data_byte;
        logic                last;
    } t_result;

endpackage

// ----- rtl/core/mfhd_channels.sv -----
interface mfhd_in_if import mfhd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface mfhd_out_if import mfhd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [NIBBLE_W-1:0] packet_type;
    logic [NIBBLE_W-1:0] packet_flags;
    logic [LEN_W-1:0]    remaining_length;
    logic [BYTE_W-1:0]   data_byte;
    logic                last;

    modport source (
        output valid, output kind, output packet_type, output packet_flags,
        output remaining_length, output data_byte, output last, input ready
    );
    modport sink (
        input valid, input kind, input packet_type, input packet_flags,
        input remaining_length, input data_byte, input last, output ready
    );
endinterface

// ----- rtl/core/mfhd_parser.sv -----
module mfhd_parser import mfhd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_res_valid,
    output t_result           o_res
);

    localparam logic [1:0] PH_CMD = 2'd0;
    localparam logic [1:0] PH_LEN = 2'd1;
    localparam logic [1:0] PH_PAY = 2'd2;

    logic [1:0]           r_phase, n_phase;
    logic [BYTE_W-1:0]    r_cmd, n_cmd;
    logic [LEN_W-1:0]     r_accum, n_accum;
    logic [LEN_CNT_W-1:0] r_len_cnt, n_len_cnt;
    logic [LEN_W-1:0]     r_left, n_left;

    logic [4:0]       shift_amt;
    logic [LEN_W-1:0] digit;
    logic [LEN_W-1:0] accum_sum;
    logic [LEN_W-1:0] left_dec;

    assign shift_amt = 5'(r_len_cnt) * 5'd7;
    assign digit     = LEN_W'(i_byte[LEN_DIGIT_W-1:0]) << shift_amt;
    assign accum_sum = r_accum + digit;
    assign left_dec  = (r_left != '0) ? r_left - LEN_W'(1) : r_left;

    always_comb begin
        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_accum   = r_accum;
        n_len_cnt = r_len_cnt;
        n_left    = r_left;

        o_res_valid            = 1'b0;
        o_res.kind             = KIND_HEADER;
        o_res.packet_type      = r_cmd[BYTE_W-1:NIBBLE_W];
        o_res.packet_flags     = r_cmd[NIBBLE_W-1:0];
        o_res.remaining_length = '0;
        o_res.data_byte        = '0;
        o_res.last             = 1'b0;

        unique case (r_phase)
            PH_LEN: begin
                if (32'(r_len_cnt) >= MAX_LENGTH_BYTES) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_ERROR;
                    o_res.last  = 1'b1;
                    n_phase     = PH_CMD;
                end else begin
                    n_len_cnt = r_len_cnt + LEN_CNT_W'(1);
                    n_accum   = accum_sum;
                    if (!i_byte[BYTE_W-1]) begin
                        o_res_valid = 1'b1;
                        if (accum_sum == '0) begin
                            o_res.last = 1'b1;
                            n_phase    = PH_CMD;
                        end else begin
                            o_res.remaining_length = accum_sum;
                            n_left                 = accum_sum;
                            n_phase                = PH_PAY;
                        end
                    end
                end
            end
            PH_PAY: begin
                o_res_valid     = 1'b1;
                o_res.kind      = KIND_PAYLOAD;
                o_res.data_byte = i_byte;
                o_res.last      = (left_dec == '0);
                n_left          = left_dec;
                if (left_dec == '0) begin
                    n_phase = PH_CMD;
                end
            end
            default: begin
                n_cmd     = i_byte;
                n_accum   = '0;
                n_len_cnt = '0;
                n_left    = '0;
                n_phase   = PH_LEN;
            end
        endcase

        if (!i_take) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_CMD;
            r_cmd     <= '0;
            r_accum   <= '0;
            r_len_cnt <= '0;
            r_left    <= '0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_cmd     <= n_cmd;
            r_accum   <= n_accum;
            r_len_cnt <= n_len_cnt;
            r_left    <= n_left;
        end
    end

endmodule

// ----- rtl/core/mqtt_fixed_header_deframer_unit.sv -----
// Channel   Modport  Payload                                         Beat taken when
// i_rx      sink     rx_byte                                         valid && ready
// o_res     source   kind, packet_type, packet_flags,                valid && ready
//                    remaining_length, data_byte, last
//
// One byte is taken per cycle when ready; a result appears in the output register the
// cycle after its byte, set by one pass of parser logic between input and output register.
// Reset is synchronous and active low and returns the parser to waiting for a command byte.
// A byte is taken whenever the output register is empty or its result is taken in the
// same cycle, so a stalled sink holds at most one pending result.
module mqtt_fixed_header_deframer_unit import mfhd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mfhd_in_if.sink    i_rx,
    mfhd_out_if.source o_res
);

    logic    take;
    logic    res_valid;
    t_result res;

    logic    r_out_valid;
    t_result r_out;

    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign take       = i_rx.valid && i_rx.ready;

    mfhd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (i_rx.rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.kind             = r_out.kind;
    assign o_res.packet_type      = r_out.packet_type;
    assign o_res.packet_flags     = r_out.packet_flags;
    assign o_res.remaining_length = r_out.remaining_length;
    assign o_res.data_byte        = r_out.data_byte;
    assign o_res.last             = r_out.last;

endmodule

// ----- verif/mfhd_stream_checker.sv -----
`timescale 1ns / 1ps

module mfhd_stream_checker import mfhd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mfhd_in_if          i_rx,
    mfhd_out_if         i_res,
    output int unsigned o_mismatches,
    output int unsigned o_outstanding
);

    typedef enum logic [1:0] {
        PH_COMMAND = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_parse_phase;

    t_parse_phase          phase      = PH_COMMAND;
    logic [BYTE_W-1:0]     cmd_byte   = '0;
    logic [LEN_W-1:0]      len_sum    = '0;
    logic [LEN_CNT_W-1:0]  len_digits = '0;
    logic [LEN_W-1:0]      bytes_left = '0;
    t_result               expected_results[$];
    t_result               want;
    int unsigned           mismatches = 0;

    assign o_mismatches = mismatches;

    initial o_outstanding = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic queue_result(input t_result r);
        expected_results = {expected_results, r};
    endtask

    function automatic t_result make_result(input logic [KIND_W-1:0] kind,
                                            input logic [LEN_W-1:0] len,
                                            input logic [BYTE_W-1:0] data,
                                            input logic last);
        t_result r;
        r.kind             = kind;
        r.packet_type      = cmd_byte[BYTE_W-1:NIBBLE_W];
        r.packet_flags     = cmd_byte[NIBBLE_W-1:0];
        r.remaining_length = len;
        r.data_byte        = data;
        r.last             = last;
        return r;
    endfunction

    // Advances the header parser by one received byte and queues any result it yields.
    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        case (phase)
            PH_LENGTH: begin
                if (len_digits >= MAX_LENGTH_BYTES) begin
                    queue_result(make_result(KIND_ERROR, '0, '0, 1'b1));
                    phase = PH_COMMAND;
                end else begin
                    len_sum = len_sum
                        + (LEN_W'(b[LEN_DIGIT_W-1:0]) << (LEN_DIGIT_W * len_digits));
                    len_digits = len_digits + 1'b1;
                    if (!b[BYTE_W-1]) begin
                        if (len_sum == '0) begin
                            queue_result(
                                make_result(KIND_HEADER, '0, '0, 1'b1));
                            phase = PH_COMMAND;
                        end else begin
                            queue_result(
                                make_result(KIND_HEADER, len_sum, '0, 1'b0));
                            bytes_left = len_sum;
                            phase = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                if (bytes_left != '0) begin
                    bytes_left = bytes_left - 1'b1;
                end
                queue_result(
                    make_result(KIND_PAYLOAD, '0, b, bytes_left == '0));
                if (bytes_left == '0) begin
                    phase = PH_COMMAND;
                end
            end
            default: begin
                cmd_byte   = b;
                len_sum    = '0;
                len_digits = '0;
                bytes_left = '0;
                phase      = PH_LENGTH;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase      = PH_COMMAND;
            cmd_byte   = '0;
            len_sum    = '0;
            len_digits = '0;
            bytes_left = '0;
            expected_results.delete();
        end else begin
            // A result beat at this edge belongs to an earlier byte, so it is matched first.
            if (i_res.valid && i_res.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, kind %0d data %0h",
                                              i_res.kind, i_res.data_byte));
                end else begin
                    want = expected_results.pop_front();
                    if (i_res.kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, predicted %0d",
                                                  i_res.kind, want.kind));
                    if (i_res.packet_type !== want.packet_type)
                        report_mismatch($sformatf("packet_type %0h, predicted %0h",
                                                  i_res.packet_type, want.packet_type));
                    if (i_res.packet_flags !== want.packet_flags)
                        report_mismatch($sformatf("packet_flags %0h, predicted %0h",
                                                  i_res.packet_flags, want.packet_flags));
                    if (i_res.remaining_length !== want.remaining_length)
                        report_mismatch($sformatf("remaining_length %0d, predicted %0d",
                                                  i_res.remaining_length,
                                                  want.remaining_length));
                    if (i_res.data_byte !== want.data_byte)
                        report_mismatch($sformatf("data_byte %0h, predicted %0h",
                                                  i_res.data_byte, want.data_byte));
                    if (i_res.last !== want.last)
                        report_mismatch($sformatf("last %0b, predicted %0b",
                                                  i_res.last, want.last));
                end
            end
            if (i_rx.valid && i_rx.ready) begin
                parse_byte(i_rx.rx_byte);
            end
        end
        o_outstanding <= expected_results.size();
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import mfhd_pkg::*;

    localparam int unsigned RANDOM_BYTES = 600;
    localparam int unsigned HOLD_START   = 300;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic              clk;
    logic              rst_n;
    int unsigned       mismatches;
    int unsigned       outstanding;
    int unsigned       cycle_count = 0;
    logic [BYTE_W-1:0] stream_bytes[$];

    mfhd_in_if  rx_if();
    mfhd_out_if res_if();

    mqtt_fixed_header_deframer_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    mfhd_stream_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_rx          (rx_if),
        .i_res         (res_if),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic append_byte(input logic [BYTE_W-1:0] b);
        stream_bytes = {stream_bytes, b};
    endtask

    task automatic queue_packet(input logic [BYTE_W-1:0] cmd, input int unsigned len,
                                input int unsigned digits, input int unsigned payload_count);
        int unsigned n;
        int unsigned tmp;
        n = 1;
        tmp = len >> LEN_DIGIT_W;
        while (tmp != 0) begin
            n++;
            tmp = tmp >> LEN_DIGIT_W;
        end
        if (digits > n) begin
            n = digits;
        end
        append_byte(cmd);
        for (int unsigned i = 0; i < n; i++) begin
            append_byte({i + 1 < n, 7'((len >> (LEN_DIGIT_W * i)) & 32'h7F)});
        end
        repeat (payload_count) append_byte(8'($urandom));
    endtask

    initial begin : stimulus
        int unsigned idx;
        int unsigned burst_left;
        int unsigned gap;
        int unsigned len;
        rst_n <= 1'b0;
        rx_if.valid <= 1'b0;
        rx_if.rx_byte <= '0;

        stream_bytes = {
            8'h00, 8'h00,
            8'hFF, 8'h80, 8'h00,
            8'h3A, 8'h02, 8'h00, 8'hFF,
            8'h12, 8'h81, 8'h80, 8'h80, 8'h00, 8'hA5,
            8'h82, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h55,
            8'hC0, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00
        };
        idx = stream_bytes.size();
        while (stream_bytes.size() < idx + RANDOM_BYTES) begin
            if ($urandom_range(0, 99) < 82) begin
                len = ($urandom_range(0, 99) < 3) ? $urandom_range(128, 300)
                                                  : $urandom_range(0, 12);
                queue_packet(8'($urandom), len, $urandom_range(1, MAX_LENGTH_BYTES), len);
            end else begin
                append_byte(8'($urandom));
                repeat (MAX_LENGTH_BYTES) append_byte({1'b1, 7'($urandom)});
                append_byte(8'($urandom));
            end
        end
        // The largest length never completes, so it closes the stream.
        queue_packet(8'($urandom), 28'hFFFFFFF, MAX_LENGTH_BYTES, 6);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idx = 0;
        burst_left = 0;
        while (idx < stream_bytes.size()) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    rx_if.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            rx_if.valid <= 1'b1;
            rx_if.rx_byte <= stream_bytes[idx];
            do @(posedge clk); while (!rx_if.ready);
            idx++;
            burst_left--;
        end
        rx_if.valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : sink_pattern
        int unsigned cyc;
        int unsigned mode;
        int unsigned mode_left;
        cyc = 0;
        mode = 0;
        mode_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            cyc++;
            if (cyc == HOLD_START) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (mode)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= 1'($urandom_range(0, 1));
                2: res_if.ready <= cyc[0];
                default: res_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

endmodule

// ----- filelist.f -----
rtl/core/mfhd_pkg.sv
rtl/core/mfhd_channels.sv
rtl/core/mfhd_parser.sv
rtl/core/mqtt_fixed_header_deframer_unit.sv
verif/mfhd_stream_checker.sv
verif/tb_top.sv
